// ----- sv/dfps_pkg.sv -----
// Shared constants, request type and command-byte table for the display frame page switch.
// No dependencies; imported by dfps_parser, dfps_emit and the top level.
package dfps_pkg;

    localparam logic [7:0]  HDR_FIRST      = 8'h5A;
    localparam logic [7:0]  HDR_SECOND     = 8'hA5;
    localparam logic [7:0]  CMD_READ_REPLY = 8'h83;
    localparam logic [8:0]  LEN_OFFSET     = 9'd3;
    localparam logic [15:0] KEY_RESET      = 16'h1000;
    localparam logic [15:0] PAGE_ONE       = 16'h0001;
    localparam logic [15:0] PAGE_TWO       = 16'h0002;
    localparam int          STORE_DEPTH    = 6;

    // outgoing command: 5A A5 07 82 00 84 5A 01 00 page
    localparam int          CMD_LEN        = 10;
    localparam logic [3:0]  CMD_LAST       = 4'(CMD_LEN - 1);

    // store slots
    localparam int SLOT_LEN  = 0;
    localparam int SLOT_CMD  = 1;
    localparam int SLOT_AHI  = 2;
    localparam int SLOT_ALO  = 3;
    localparam int SLOT_VHI  = 4;
    localparam int SLOT_VLO  = 5;

    typedef struct packed {
        logic       fire;
        logic [7:0] page;
    } t_fire;

    function automatic logic [7:0] cmd_byte(input logic [3:0] idx, input logic [7:0] page);
        logic [7:0] b;
        case (idx)
            4'd0: b = 8'h5A;
            4'd1: b = 8'hA5;
            4'd2: b = 8'h07;
            4'd3: b = 8'h82;
            4'd4: b = 8'h00;
            4'd5: b = 8'h84;
            4'd6: b = 8'h5A;
            4'd7: b = 8'h01;
            4'd8: b = 8'h00;
            4'd9: b = page;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

// ----- sv/dfps_parser.sv -----
// Frame parser: header hunt, byte count, field store and frame judgment.
// Depends on dfps_pkg.
module dfps_parser #(
    parameter int BUFFER_BYTES = 32
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_take,
    input  logic [7:0]      i_byte,
    input  logic [15:0]     i_key,
    output dfps_pkg::t_fire o_fire
);
    import dfps_pkg::*;

    localparam int CW = $clog2(BUFFER_BYTES);

    logic [CW-1:0] r_count, n_count;
    logic [7:0]    r_store [STORE_DEPTH];
    logic [7:0]    n_store [STORE_DEPTH];
    logic [CW:0]   inc;
    logic [8:0]    need;
    logic          done;
    logic          hit;
    logic [15:0]   addr;
    logic [15:0]   value;

    always_comb begin
        for (int k = 0; k < STORE_DEPTH; k++) begin
            n_store[k] = r_store[k];
        end
        n_count = r_count;
        inc     = {1'b0, r_count} + (CW+1)'(1);
        need    = 9'd0;
        done    = 1'b0;
        if (r_count == CW'(0)) begin
            n_count = (i_byte == HDR_FIRST) ? CW'(1) : CW'(0);
        end else if (r_count == CW'(1)) begin
            n_count = (i_byte == HDR_SECOND) ? CW'(2) : CW'(0);
        end else begin
            if (r_count == CW'(2)) n_store[SLOT_LEN] = i_byte;
            if (r_count == CW'(3)) n_store[SLOT_CMD] = i_byte;
            if (r_count == CW'(4)) n_store[SLOT_AHI] = i_byte;
            if (r_count == CW'(5)) n_store[SLOT_ALO] = i_byte;
            if (r_count == CW'(7)) n_store[SLOT_VHI] = i_byte;
            if (r_count == CW'(8)) n_store[SLOT_VLO] = i_byte;
            // length + 3 at 9 bits, never wraps
            need = {1'b0, n_store[SLOT_LEN]} + LEN_OFFSET;
            done = 9'(inc) >= need;
            if (done || inc >= (CW+1)'(BUFFER_BYTES)) begin
                n_count = CW'(0);
            end else begin
                n_count = inc[CW-1:0];
            end
        end
    end

    assign addr  = {n_store[SLOT_AHI], n_store[SLOT_ALO]};
    assign value = {n_store[SLOT_VHI], n_store[SLOT_VLO]};
    assign hit   = (n_store[SLOT_CMD] == CMD_READ_REPLY) && (addr == i_key) &&
                   ((value == PAGE_ONE) || (value == PAGE_TWO));

    assign o_fire.fire = i_take && done && hit;
    assign o_fire.page = n_store[SLOT_VLO];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            for (int k = 0; k < STORE_DEPTH; k++) begin
                r_store[k] <= 8'h00;
            end
        end else if (i_take) begin
            r_count <= n_count;
            for (int k = 0; k < STORE_DEPTH; k++) begin
                r_store[k] <= n_store[k];
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_count) < BUFFER_BYTES)
        else $error("receive count reached buffer size");
    a_header_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_take && r_count == CW'(1) && i_byte != HDR_SECOND) |=> (r_count == CW'(0)))
        else $error("bad second header byte did not restart hunt");
    a_fire_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_fire.fire |=> (r_count == CW'(0)))
        else $error("frame fired without count returning to zero");
`endif

endmodule

// ----- sv/dfps_emit.sv -----
// Command emitter: one pending request slot plus a 10-byte command sequencer.
// Depends on dfps_pkg.
module dfps_emit (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  dfps_pkg::t_fire i_fire,
    output logic            o_pend,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output logic [7:0]      o_transmit_byte,
    output logic            o_frame_end
);
    import dfps_pkg::*;

    logic       r_pend_valid, n_pend_valid;
    logic [7:0] r_pend_page,  n_pend_page;
    logic       r_busy,       n_busy;
    logic [3:0] r_idx,        n_idx;
    logic [7:0] r_page,       n_page;
    logic       take;
    logic       last;
    logic       load;

    assign take = r_busy && !i_out_stall;
    assign last = take && (r_idx == CMD_LAST);
    assign load = r_pend_valid && (!r_busy || last);

    always_comb begin
        n_pend_valid = r_pend_valid;
        n_pend_page  = r_pend_page;
        n_busy       = r_busy;
        n_idx        = r_idx;
        n_page       = r_page;
        if (i_fire.fire) begin
            n_pend_valid = 1'b1;
            n_pend_page  = i_fire.page;
        end else if (load) begin
            n_pend_valid = 1'b0;
        end
        if (load) begin
            n_busy = 1'b1;
            n_idx  = 4'd0;
            n_page = r_pend_page;
        end else if (last) begin
            n_busy = 1'b0;
        end else if (take) begin
            n_idx = r_idx + 4'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
            r_busy       <= 1'b0;
            r_idx        <= 4'd0;
        end else begin
            r_pend_valid <= n_pend_valid;
            r_busy       <= n_busy;
            r_idx        <= n_idx;
        end
        r_pend_page <= n_pend_page;
        r_page      <= n_page;
    end

    assign o_pend          = r_pend_valid;
    assign o_out_valid     = r_busy;
    assign o_transmit_byte = cmd_byte(r_idx, r_page);
    assign o_frame_end     = r_busy && (r_idx == CMD_LAST);

`ifndef NO_ASSERTIONS
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_idx <= CMD_LAST))
        else $error("command index out of range");
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire.fire |-> !r_pend_valid)
        else $error("pending request overwritten");
    a_pend_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend_valid && !load) |=> (r_pend_valid && $stable(r_pend_page)))
        else $error("pending request lost");
    a_end_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (last && !r_pend_valid) |=> !r_busy)
        else $error("emitter stayed busy after last byte");
`endif

endmodule

// ----- sv/display_frame_page_switch_unit.sv -----
// Top level of the display frame page switch: key register, parser and command emitter.
// Depends on dfps_pkg, dfps_parser and dfps_emit.
//
//  channel  | direction | handshake                 | payload
//  ---------+-----------+---------------------------+---------------------------------
//  in       | to block  | i_in_valid / o_in_stall   | i_received_byte
//  out      | from blk  | o_out_valid / i_out_stall | o_transmit_byte, o_frame_end
//  cfg      | to block  | i_cfg_valid / o_cfg_ready | i_page_key_address
//
//  Each received byte is parsed in the cycle it is accepted; a matching frame
//  leaves one request in a pending slot, the emitter loads it from there once
//  idle or on its last byte, and sends its 10 bytes at one per cycle when not
//  stalled. o_in_stall is high while that slot is full: after each matching
//  frame until the load, longer while it waits behind a command still being sent.
//  Reset (synchronous, active low) clears count, field store, slot and emitter;
//  the key register returns to 0x1000. No clearing pass after reset.
module display_frame_page_switch_unit #(
    parameter int BUFFER_BYTES = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // received bytes
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_received_byte,
    // outgoing command bytes
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_transmit_byte,
    output logic        o_frame_end,
    // key address register write
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_page_key_address
);
    import dfps_pkg::*;

    logic [15:0] r_key;
    logic        in_take;
    logic        pend;
    t_fire       fire;

    // register writes must come only while idle; the block does not enforce it, so always ready
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key <= KEY_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_key <= i_page_key_address;
        end
    end

    // hold input while a request already waits for the emitter
    assign o_in_stall = pend;
    assign in_take    = i_in_valid && !o_in_stall;

    dfps_parser #(
        .BUFFER_BYTES(BUFFER_BYTES)
    ) u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (in_take),
        .i_byte  (i_received_byte),
        .i_key   (r_key),
        .o_fire  (fire)
    );

    dfps_emit u_emit (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_fire          (fire),
        .o_pend          (pend),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_transmit_byte (o_transmit_byte),
        .o_frame_end     (o_frame_end)
    );

endmodule

// ----- tb/sv/display_frame_page_switch_unit_test.sv -----
`timescale 1ns / 100ps
// Testbench for display_frame_page_switch_unit: a queue-fed byte driver, a command-byte monitor,
// a frame parser model and a key register walk. Depends on dfps_pkg and the unit's RTL.
module display_frame_page_switch_unit_test;
    import dfps_pkg::*;

    localparam int BUF_BYTES   = 32;
    localparam int STALL_LIMIT = 4000;
    localparam int SETTLE      = 16;

    typedef struct {
        logic [7:0] data;
        logic       last;
    } t_tx_byte;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic [7:0]  i_received_byte = '0;
    logic        i_out_stall = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic [15:0] i_page_key_address = '0;
    logic        o_in_stall;
    logic        o_out_valid;
    logic [7:0]  o_transmit_byte;
    logic        o_frame_end;
    logic        o_cfg_ready;

    display_frame_page_switch_unit #(.BUFFER_BYTES(BUF_BYTES)) i_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_received_byte    (i_received_byte),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_transmit_byte    (o_transmit_byte),
        .o_frame_end        (o_frame_end),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_page_key_address (i_page_key_address)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    logic [7:0] rx_stream [$];      // bytes waiting to be offered
    t_tx_byte   page_cmd_due [$];   // command bytes the block still owes
    int         error_count = 0;
    int         cycle_count = 0;

    // parser model state
    logic [15:0] key_model = KEY_RESET;
    logic [5:0]  rx_count = '0;
    logic [7:0]  kept [STORE_DEPTH] = '{default: 8'h00};

    // no idling at all in this window
    function automatic logic take_break();
        if (cycle_count >= 200 && cycle_count < 500)
            return 1'b0;
        return $urandom_range(0, 99) < 15;
    endfunction

    function automatic void push_page_cmd(input logic [7:0] page);
        logic [7:0] seq [CMD_LEN];
        seq = '{8'h5A, 8'hA5, 8'h07, 8'h82, 8'h00, 8'h84, 8'h5A, 8'h01, 8'h00, page};
        for (int k = 0; k < CMD_LEN; k++)
            page_cmd_due.push_back('{data: seq[k], last: (k == CMD_LEN - 1)});
    endfunction

    // frame parser model: one received byte in, page command bytes queued out
    function automatic void parse_received_byte(input logic [7:0] b);
        int next_count;
        int slot;
        logic [15:0] addr;
        logic [15:0] value;
        if (rx_count == 0) begin
            if (b == HDR_FIRST)
                rx_count = 6'd1;
        end else if (rx_count == 1) begin
            rx_count = (b == HDR_SECOND) ? 6'd2 : 6'd0;
        end else begin
            case (rx_count)
                6'd2: slot = SLOT_LEN;
                6'd3: slot = SLOT_CMD;
                6'd4: slot = SLOT_AHI;
                6'd5: slot = SLOT_ALO;
                6'd7: slot = SLOT_VHI;
                6'd8: slot = SLOT_VLO;
                default: slot = -1;
            endcase
            if (slot >= 0)
                kept[slot] = b;
            next_count = int'(rx_count) + 1;
            // length + 3 at full width, no 8-bit wrap
            if (next_count >= int'(kept[SLOT_LEN]) + int'(LEN_OFFSET)) begin
                addr  = {kept[SLOT_AHI], kept[SLOT_ALO]};
                value = {kept[SLOT_VHI], kept[SLOT_VLO]};
                if (kept[SLOT_CMD] == CMD_READ_REPLY && addr == key_model &&
                    (value == PAGE_ONE || value == PAGE_TWO))
                    push_page_cmd(value[7:0]);
                next_count = 0;
            end
            // overlong frame: silent restart
            if (next_count >= BUF_BYTES)
                next_count = 0;
            rx_count = 6'(next_count);
        end
    endfunction

    // driver: offers queued bytes, holds a stalled request, models each accepted byte
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (i_in_valid && o_in_stall) begin
            // hold request and payload
        end else begin
            if (i_in_valid)
                parse_received_byte(i_received_byte);
            if (rx_stream.size() != 0 && !take_break()) begin
                i_in_valid      <= 1'b1;
                i_received_byte <= rx_stream.pop_front();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // monitor: checks each accepted command byte against the oldest one owed
    always @(posedge i_clk) begin
        t_tx_byte want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (page_cmd_due.size() == 0) begin
                $display("%0t: unexpected command byte %02h end %0b",
                         $time, o_transmit_byte, o_frame_end);
                error_count++;
            end else begin
                want = page_cmd_due.pop_front();
                if (o_transmit_byte !== want.data) begin
                    $display("%0t: transmit_byte expected %02h actual %02h",
                             $time, want.data, o_transmit_byte);
                    error_count++;
                end
                if (o_frame_end !== want.last) begin
                    $display("%0t: frame_end expected %0b actual %0b",
                             $time, want.last, o_frame_end);
                    error_count++;
                end
            end
        end
        i_out_stall <= take_break();
    end

    // watchdog on cycles with no handshake on any channel
    always @(posedge i_clk) begin
        int quiet;
        cycle_count <= cycle_count + 1;
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet = 0;
        end else begin
            quiet++;
            if (quiet >= STALL_LIMIT) begin
                $display("display_frame_page_switch_unit verification failed");
                $finish;
            end
        end
    end

    task automatic write_page_key(input logic [15:0] key);
        @(posedge i_clk);
        i_cfg_valid        <= 1'b1;
        i_page_key_address <= key;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        key_model = key;
        i_cfg_valid <= 1'b0;
    endtask

    // wait until every byte is taken and every command byte has come out
    task automatic drain();
        while (rx_stream.size() != 0 || i_in_valid || page_cmd_due.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // mostly well-formed frames with random content, plus noise and broken headers
    task automatic queue_random_traffic(input int target);
        int queued;
        int roll;
        int len;
        int total;
        logic [7:0]  cmd;
        logic [15:0] addr;
        logic [15:0] value;
        logic [7:0]  head [9];
        queued = 0;
        while (queued < target) begin
            roll = $urandom_range(0, 99);
            if (roll < 8) begin
                repeat ($urandom_range(1, 4)) rx_stream.push_back(8'($urandom_range(0, 255)));
            end else if (roll < 14) begin
                rx_stream.push_back(HDR_FIRST);
                rx_stream.push_back(8'($urandom_range(0, 8'hA4)));
            end else begin
                roll = $urandom_range(0, 99);
                if (roll < 60)      len = 6;
                else if (roll < 75) len = $urandom_range(0, 5);
                else if (roll < 92) len = $urandom_range(7, BUF_BYTES - 4);
                else                len = $urandom_range(BUF_BYTES - 3, 255);
                cmd  = ($urandom_range(0, 99) < 85) ? CMD_READ_REPLY : 8'($urandom_range(0, 255));
                addr = ($urandom_range(0, 99) < 80) ? key_model : 16'($urandom_range(0, 65535));
                roll = $urandom_range(0, 99);
                if (roll < 40)      value = PAGE_ONE;
                else if (roll < 80) value = PAGE_TWO;
                else if (roll < 90) value = 16'($urandom_range(0, 3));
                else                value = 16'($urandom_range(0, 65535));
                head = '{HDR_FIRST, HDR_SECOND, 8'(len), cmd, addr[15:8], addr[7:0],
                         8'($urandom_range(0, 255)), value[15:8], value[7:0]};
                total = (len + 3 > BUF_BYTES) ? BUF_BYTES : len + 3;
                for (int k = 0; k < total; k++)
                    rx_stream.push_back((k < 9) ? head[k] : 8'($urandom_range(0, 255)));
                queued += total;
            end
        end
    endtask

    initial begin
        logic [15:0] key_walk [4];
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed, reset key 0x1000: byte extremes, header restart on 5A 5A,
        // page 1 frame, short frame judged on stale fields, wrong command
        rx_stream = '{8'h00, 8'hFF, 8'h5A, 8'h5A,
                      8'h5A, 8'hA5, 8'h06, 8'h83, 8'h10, 8'h00, 8'h3C, 8'h00, 8'h01,
                      8'h5A, 8'hA5, 8'h00,
                      8'h5A, 8'hA5, 8'h06, 8'h84, 8'h10, 8'h00, 8'h00, 8'h00, 8'h02};
        drain();

        key_walk = '{16'h0000, 16'hFFFF, 16'($urandom_range(0, 65535)), KEY_RESET};
        foreach (key_walk[p]) begin
            write_page_key(key_walk[p]);
            queue_random_traffic(44);
            drain();
        end

        if (error_count == 0)
            $display("display_frame_page_switch_unit verification clean");
        else
            $display("display_frame_page_switch_unit verification failed");
        $finish;
    end

endmodule
